// File: sv/base64_stream_encoder_core_defines.svh
// Assertion macros shared by the base64 encoder checker.
// No dependencies; expects i_clk and i_rst_n in the using scope.
`ifndef BASE64_STREAM_ENCODER_CORE_DEFINES_SVH
`define BASE64_STREAM_ENCODER_CORE_DEFINES_SVH

// Consequent checked in the cycle after the antecedent, outside reset.
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

// Consequent checked in the same cycle, outside reset.
`define B64E_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// Next-cycle check that also runs during reset.
`define B64E_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

// File: sv/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 encoder.
// No dependencies.
package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // number of '=' characters closing a group
    localparam logic [1:0] PADS_NONE = 2'd0;
    localparam logic [1:0] PADS_ONE  = 2'd1;
    localparam logic [1:0] PADS_TWO  = 2'd2;

    typedef struct packed {
        logic [23:0] bits;   // 24-bit group, first byte in 23:16
        logic [1:0]  pads;
        logic        last;   // group closes the message
    } t_group;

    function automatic logic [6:0] b64_char(input logic [5:0] six);
        logic [6:0] r;
        case (six) inside
            [6'd0:6'd25]:  r = 7'h41 + {1'b0, six};
            [6'd26:6'd51]: r = 7'h61 + {1'b0, six - 6'd26};
            [6'd52:6'd61]: r = 7'h30 + {1'b0, six - 6'd52};
            6'd62:         r = 7'h2B;
            default:       r = 7'h2F;
        endcase
        return r;
    endfunction

endpackage

// File: sv/b64e_front.sv
// Front end: accepts bytes, holds up to two pending bytes, forms 3-byte groups and
// pads the last group of a message. Depends on b64e_pkg.
module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    input  logic       i_queue_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_group     o_push_group
);

    logic [15:0] r_pend, n_pend;
    logic [1:0]  r_count, n_count;
    logic        accept;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    always_comb begin
        n_pend       = r_pend;
        n_count      = r_count;
        o_push       = 1'b0;
        o_push_group = '{bits: {r_pend, i_data_byte}, pads: PADS_NONE, last: i_end_of_message};
        if (accept) begin
            if (r_count >= 2'd2) begin
                o_push  = 1'b1;
                n_pend  = '0;
                n_count = '0;
            end else if (!i_end_of_message) begin
                n_pend  = {r_pend[7:0], i_data_byte};
                n_count = r_count + 2'd1;
            end else begin
                o_push  = 1'b1;
                n_pend  = '0;
                n_count = '0;
                if (r_count == 2'd1) begin
                    o_push_group = '{bits: {r_pend[7:0], i_data_byte, 8'h00},
                                     pads: PADS_ONE, last: 1'b1};
                end else begin
                    o_push_group = '{bits: {i_data_byte, 16'h0000},
                                     pads: PADS_TWO, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_count <= '0;
        end else begin
            r_pend  <= n_pend;
            r_count <= n_count;
        end
    end

endmodule

// File: sv/b64e_queue.sv
// Short group queue between front and back ends.
// Depends on b64e_pkg.
module b64e_queue
    import b64e_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_push_group,
    input  logic   i_pop,
    output t_group o_pop_group,
    output logic   o_full,
    output logic   o_empty
);

    t_group            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty     = (r_cnt == '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && !o_empty;
    assign o_pop_group = r_mem[r_rd];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: sv/b64e_back.sv
// Back end: walks a group out as four characters through an output register.
// Depends on b64e_pkg.
module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_group     i_group,
    input  logic       i_queue_empty,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [6:0] o_code_char,
    output logic       o_final_char
);

    t_group     r_grp;
    logic       r_grp_valid, n_grp_valid;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid;
    logic [6:0] r_char;
    logic       r_final;

    logic       out_free, emit, take, is_pad;
    logic [5:0] six;
    logic [6:0] char_next;

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = out_free && r_grp_valid;
    assign take     = !r_grp_valid || (emit && r_idx == 2'd3);
    assign o_pop    = take && !i_queue_empty;

    always_comb begin
        case (r_idx)
            2'd0:    six = r_grp.bits[23:18];
            2'd1:    six = r_grp.bits[17:12];
            2'd2:    six = r_grp.bits[11:6];
            default: six = r_grp.bits[5:0];
        endcase
        is_pad    = (r_idx == 2'd3 && r_grp.pads != PADS_NONE)
                 || (r_idx == 2'd2 && r_grp.pads == PADS_TWO);
        char_next = is_pad ? PAD_CHAR : b64_char(six);
    end

    always_comb begin
        n_grp_valid = r_grp_valid;
        n_idx       = r_idx;
        if (emit) begin
            n_idx = r_idx + 2'd1;
            if (r_idx == 2'd3) begin
                n_grp_valid = 1'b0;
            end
        end
        if (o_pop) begin
            n_grp_valid = 1'b1;
            n_idx       = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (out_free) begin
            r_char  <= char_next;
            r_final <= (r_idx == 2'd3) && r_grp.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_grp_valid <= n_grp_valid;
            r_idx       <= n_idx;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_char  = r_char;
    assign o_final_char = r_final;

endmodule

// File: sv/base64_stream_encoder_core.sv
// Base64 stream encoder. A completed group passes the queue, the group register and
// the output register before its first character leaves; the other three follow it.
// Throughput: one character per cycle unless the output stalls, set by the
// single-character output register; a 2-group queue takes 1 byte per cycle until full.
// Synchronous active-low reset empties pending bytes, queue and output register.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
module base64_stream_encoder_core
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_code_char,
    output logic       o_final_char
);

    t_group push_group, pop_group;
    logic   push, pop, q_full, q_empty;

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_queue_full     (q_full),
        .o_in_stall       (o_in_stall),
        .o_push           (push),
        .o_push_group     (push_group)
    );

    b64e_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_group (push_group),
        .i_pop        (pop),
        .o_pop_group  (pop_group),
        .o_full       (q_full),
        .o_empty      (q_empty)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group       (pop_group),
        .i_queue_empty (q_empty),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_code_char   (o_code_char),
        .o_final_char  (o_final_char)
    );

endmodule

// File: sv/b64e_checker.sv
// Port-level checker for the base64 encoder, bound to the top level.
// Depends on base64_stream_encoder_core_defines.svh.
`include "base64_stream_encoder_core_defines.svh"

module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [6:0] o_code_char
);

    logic char_ok;

    assign char_ok = (o_code_char >= 7'h41 && o_code_char <= 7'h5A)
                  || (o_code_char >= 7'h61 && o_code_char <= 7'h7A)
                  || (o_code_char >= 7'h30 && o_code_char <= 7'h39)
                  || o_code_char == 7'h2B || o_code_char == 7'h2F
                  || o_code_char == 7'h3D;

    // a held character stays offered
    `B64E_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // only alphabet characters or padding ever leave
    `B64E_ASSERT_SAME(a_char_legal, o_out_valid, char_ok)

    // reset leaves the input unstalled and nothing offered
    `B64E_ASSERT_NEXT_ALWAYS(a_reset_clean, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_code_char (o_code_char)
);
